// ===== sv/hks_pkg.sv =====
package hks_pkg;

  // Default geometry of the set
  localparam int unsigned BUCKETS_DEF   = 32;
  localparam int unsigned WAYS_DEF      = 4;
  localparam int unsigned KEY_WIDTH_DEF = 64;

  // djb2 hash constants
  localparam logic [63:0] HASH_SEED  = 64'd5381;
  localparam int unsigned HASH_SHIFT = 5;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

endpackage

// ===== sv/hks_hash.sv =====
module hks_hash #(
  parameter int unsigned BUCKETS = hks_pkg::BUCKETS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [63:0]                key_i,
  output logic                       done_o,
  output logic [$clog2(BUCKETS)-1:0] bucket_o
);

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned TW = BW + 4;
  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam logic [TW-1:0] MOD_B = TW'(BUCKETS);
  localparam logic [3:0] BYTE_LAST = 4'd7;
  localparam logic [3:0] NIB_LAST  = 4'd15;

  typedef enum logic [1:0] {
    H_IDLE,
    H_BYTE,
    H_MOD
  } hstate_e;

  hstate_e        state_q;
  logic [3:0]     cnt_q;
  logic [63:0]    h_q;
  logic [63:0]    key_sh_q;
  logic [BW-1:0]  r_q;
  logic [BW-1:0]  bucket_q;
  logic           done_q;

  logic [63:0]    byte_ext;
  logic [63:0]    h_d;
  logic [TW-1:0]  t;
  logic [BW-1:0]  r_d;

  // One djb2 step on the low byte, sign-extended
  always_comb begin
    byte_ext = {{56{key_sh_q[7]}}, key_sh_q[7:0]};
    h_d      = (h_q << hks_pkg::HASH_SHIFT) + h_q + byte_ext;
  end

  // Fold the next nibble into the residue: subtract 8B, 4B, 2B, B where they fit
  always_comb begin
    t = {r_q, h_q[63:60]};
    for (int j = 3; j >= 0; j--) begin
      if (t >= (MOD_B << j)) begin
        t = t - (MOD_B << j);
      end
    end
    r_d = t[BW-1:0];
  end

  // Sequence: eight hash steps, then, when BUCKETS is not a power of two, sixteen nibbles of reduction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= H_IDLE;
      cnt_q    <= '0;
      h_q      <= '0;
      key_sh_q <= '0;
      r_q      <= '0;
      bucket_q <= '0;
      done_q   <= 1'b0;
    end else begin
      case (state_q)
        H_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            h_q      <= hks_pkg::HASH_SEED;
            key_sh_q <= key_i;
            cnt_q    <= '0;
            state_q  <= H_BYTE;
          end
        end
        H_BYTE: begin
          h_q      <= h_d;
          key_sh_q <= key_sh_q >> 8;
          if (cnt_q == BYTE_LAST) begin
            cnt_q <= '0;
            if (IS_POW2) begin
              bucket_q <= h_d[BW-1:0];
              done_q   <= 1'b1;
              state_q  <= H_IDLE;
            end else begin
              r_q     <= '0;
              state_q <= H_MOD;
            end
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        H_MOD: begin
          h_q   <= h_q << 4;
          r_q   <= r_d;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == NIB_LAST) begin
            bucket_q <= r_d;
            done_q   <= 1'b1;
            state_q  <= H_IDLE;
          end
        end
        default: begin
          state_q <= H_IDLE;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign bucket_o = bucket_q;

endmodule

// ===== sv/hashed_key_set_top.sv =====
// Bucketed key set. Each word carries a command (add, look up, remove) and a key;
// one result word comes back per command. The bucket is picked by a djb2 hash of
// the key's eight bytes, computed one byte per cycle, then reduced modulo BUCKETS
// one nibble per cycle when BUCKETS is not a power of two. A command occupies the
// block from acceptance to the next acceptance through the hash steps, the
// reduction steps where needed, a read of the bucket row from memory, a compare of
// all ways with the row written back, and a return to idle before the next word
// is taken. A finished result waits in the output register while the next command
// is taken; if it is still unread when the next result is ready, that command holds
// in the compare step until the output is free. After reset the valid marks are
// swept to zero, one bucket per cycle, so no command is taken until every bucket
// has been cleared.
module hashed_key_set_top #(
  parameter int unsigned BUCKETS   = hks_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS      = hks_pkg::WAYS_DEF,
  parameter int unsigned KEY_WIDTH = hks_pkg::KEY_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic        was_present_o,
  output logic        bucket_full_o,
  output logic [63:0] stored_key_o
);

  localparam int unsigned BW    = $clog2(BUCKETS);
  localparam int unsigned WIDX  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W = WAYS * KEY_WIDTH;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_CMP
  } state_e;

  state_e                state_q;
  logic [BW-1:0]         clr_q;
  logic [1:0]            cmd_q;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [BW-1:0]         bucket_q;
  logic                  out_valid_q;
  logic                  ok_q;
  logic                  present_q;
  logic                  full_q;
  logic [63:0]           stored_q;

  // Bucket rows: keys and valid marks
  logic [ROW_W-1:0]      key_mem [BUCKETS];
  logic [WAYS-1:0]       vld_mem [BUCKETS];
  logic [ROW_W-1:0]      key_row_q;
  logic [WAYS-1:0]       vld_row_q;

  logic                  accept;
  logic                  hash_done;
  logic [BW-1:0]         hash_bucket;
  logic                  commit;

  logic [WAYS-1:0]       hit_vec;
  logic [WAYS-1:0]       free_vec;
  logic [WIDX-1:0]       hit_idx;
  logic [WIDX-1:0]       free_idx;
  logic                  hit_any;
  logic                  free_any;
  logic                  res_ok;
  logic                  res_present;
  logic                  res_full;
  logic [63:0]           res_stored;
  logic                  key_we_c;
  logic                  vld_we_c;
  logic [ROW_W-1:0]      key_row_d;
  logic [WAYS-1:0]       vld_row_d;
  logic                  key_we;
  logic                  vld_we;
  logic [BW-1:0]         vld_waddr;
  logic [WAYS-1:0]       vld_wdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_CMP) && (!out_valid_q || out_ready_i);

  hks_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .key_i    (64'(key_i[KEY_WIDTH-1:0])),
    .done_o   (hash_done),
    .bucket_o (hash_bucket)
  );

  // Compare every way of the row and work out the result
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = vld_row_q[w] && (key_row_q[w*KEY_WIDTH +: KEY_WIDTH] == key_q);
      free_vec[w] = !vld_row_q[w];
    end
    hit_any  = |hit_vec;
    free_any = |free_vec;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_idx = WIDX'(w);
      end
      if (free_vec[w]) begin
        free_idx = WIDX'(w);
      end
    end

    res_ok      = 1'b0;
    res_present = 1'b0;
    res_full    = 1'b0;
    res_stored  = '0;
    key_we_c    = 1'b0;
    vld_we_c    = 1'b0;
    key_row_d   = key_row_q;
    vld_row_d   = vld_row_q;

    case (cmd_q)
      hks_pkg::CMD_ADD: begin
        res_present = hit_any;
        if (hit_any) begin
          res_ok = 1'b1;
        end else if (free_any) begin
          res_ok   = 1'b1;
          key_we_c = 1'b1;
          vld_we_c = 1'b1;
          key_row_d[free_idx*KEY_WIDTH +: KEY_WIDTH] = key_q;
          vld_row_d[free_idx] = 1'b1;
        end else begin
          res_full = 1'b1;
        end
      end
      hks_pkg::CMD_LOOKUP: begin
        res_present = hit_any;
        if (hit_any) begin
          res_ok     = 1'b1;
          res_stored = 64'(key_row_q[hit_idx*KEY_WIDTH +: KEY_WIDTH]);
        end
      end
      hks_pkg::CMD_REMOVE: begin
        res_present = hit_any;
        if (hit_any) begin
          res_ok   = 1'b1;
          vld_we_c = 1'b1;
          vld_row_d[hit_idx] = 1'b0;
        end
      end
      default: begin
        res_present = 1'b0;
      end
    endcase
  end

  // Write-back controls; the sweep after reset clears valid marks only
  assign key_we    = commit && key_we_c;
  assign vld_we    = (state_q == S_CLEAR) || (commit && vld_we_c);
  assign vld_waddr = (state_q == S_CLEAR) ? clr_q : bucket_q;
  assign vld_wdata = (state_q == S_CLEAR) ? '0 : vld_row_d;

  // Read the bucket row as the hash completes
  always_ff @(posedge clk_i) begin
    if (hash_done) begin
      key_row_q <= key_mem[hash_bucket];
      vld_row_q <= vld_mem[hash_bucket];
    end
  end

  // Write back the modified row
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[bucket_q] <= key_row_d;
    end
    if (vld_we) begin
      vld_mem[vld_waddr] <= vld_wdata;
    end
  end

  // Sequence commands and hold the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cmd_q       <= '0;
      key_q       <= '0;
      bucket_q    <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      present_q   <= 1'b0;
      full_q      <= 1'b0;
      stored_q    <= '0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == BW'(BUCKETS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= command_i;
            key_q   <= key_i[KEY_WIDTH-1:0];
            state_q <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            bucket_q <= hash_bucket;
            state_q  <= S_CMP;
          end
        end
        S_CMP: begin
          if (commit) begin
            ok_q      <= res_ok;
            present_q <= res_present;
            full_q    <= res_full;
            stored_q  <= res_stored;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign was_present_o = present_q;
  assign bucket_full_o = full_q;
  assign stored_key_o  = stored_q;

  // One command at a time: an accepted word closes the input side
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input accepted while a command is in flight");

  // The row read always lands in the compare state
  a_read_then_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |=> (state_q == S_CMP))
    else $error("hash completed outside the hash state");

  // A full bucket is only ever reported for a failed add of an absent key
  a_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bucket_full_o |-> !ok_o && !was_present_o)
    else $error("bucket full reported together with success");

  // A returned key implies a hit
  a_stored_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (stored_key_o != '0) |-> ok_o && was_present_o)
    else $error("stored key returned without a hit");

endmodule
